@@ design/qsun_pkg.sv @@
// Shared types, constants and helpers for the quadric surface unit normal block.
package qsun_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 16;
  localparam int DIFF_W      = COORD_WIDTH + 1;
  localparam int NORM_W      = 31;
  localparam int SQ_W        = 2 * NORM_W;
  localparam int SUM_W       = 64;
  localparam int ROOT_W      = SUM_W / 2;
  localparam int QUO_W       = 31;
  localparam int DIV_W       = NORM_W + 31;
  localparam int OUT_W       = 32;
  localparam int LEN_W       = $clog2(DIFF_W + 1);
  localparam int LANES       = 3;

  typedef enum logic [3:0] {
    OP_P, OP_PX, OP_PY, OP_PZ, OP_SO, OP_S, OP_SX, OP_SY, OP_SZ,
    OP_CXP, OP_CYP, OP_CZP, OP_CX, OP_CY, OP_CZ
  } op_e;

  typedef struct packed {
    logic [3:0]                    operation;
    logic signed [COORD_WIDTH-1:0] param_a;
    logic signed [COORD_WIDTH-1:0] param_b;
    logic signed [COORD_WIDTH-1:0] param_c;
    logic signed [COORD_WIDTH-1:0] pos_x;
    logic signed [COORD_WIDTH-1:0] pos_y;
    logic signed [COORD_WIDTH-1:0] pos_z;
  } req_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] norm_x;
    logic signed [OUT_W-1:0] norm_y;
    logic signed [OUT_W-1:0] norm_z;
    logic                    degenerate;
  } rsp_t;

  typedef struct packed {
    logic [LANES-1:0]             neg;
    logic                         degen;
    logic [LANES-1:0][NORM_W-1:0] mag;
  } side_t;

  function automatic logic [LEN_W-1:0] bit_len(input logic [DIFF_W-1:0] v);
    logic [LEN_W-1:0] n;
    n = '0;
    for (int i = 0; i < DIFF_W; i++) begin
      if (v[i]) n = LEN_W'(i + 1);
    end
    return n;
  endfunction

endpackage

@@ design/qsun_if.sv @@
// Valid/ready channel interfaces for request and response items.
interface qsun_req_if;
  logic              valid;
  logic              ready;
  qsun_pkg::req_t    data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface qsun_rsp_if;
  logic              valid;
  logic              ready;
  qsun_pkg::rsp_t    data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ design/quadric_surface_unit_normal.sv @@
// Top level: unit normal of plane, sphere and cylinder surfaces.
//
//   channel | role   | item
//   --------+--------+-------------------------------------------------
//   req     | sink   | surface kind, three parameters, point (Q16.16)
//   rsp     | source | unit normal (Q1.30) and degenerate flag
//
// The pipeline has six front stages, 32 square-root stages, one
// dividend stage, 31 divider stages and the output register.
// One item enters per cycle while the response is not held; the square
// root and the divider lanes are fully pipelined, one bit per stage.
// Synchronous reset clears the valid bits only.
// A held response freezes the whole pipeline; nothing is dropped.
module quadric_surface_unit_normal (
  input logic         clk,
  input logic         rst,
  qsun_req_if.sink    req,
  qsun_rsp_if.source  rsp
);
  import qsun_pkg::*;

  logic en;
  logic rsp_vld;
  rsp_t rsp_data;

  assign en        = !rsp_vld || rsp.ready;
  assign req.ready = en;
  assign rsp.valid = rsp_vld;
  assign rsp.data  = rsp_data;

  // raw vector
  logic signed [DIFF_W-1:0] a, b, c, x, y, z, one_v;
  logic signed [DIFF_W-1:0] v_next [LANES];
  logic                     deg_next;

  assign a     = DIFF_W'(req.data.param_a);
  assign b     = DIFF_W'(req.data.param_b);
  assign c     = DIFF_W'(req.data.param_c);
  assign x     = DIFF_W'(req.data.pos_x);
  assign y     = DIFF_W'(req.data.pos_y);
  assign z     = DIFF_W'(req.data.pos_z);
  assign one_v = DIFF_W'(64'd1 << FRAC_BITS);

  always_comb begin
    v_next[0] = '0;
    v_next[1] = '0;
    v_next[2] = '0;
    deg_next  = 1'b0;
    case (op_e'(req.data.operation))
      OP_P:   begin v_next[0] = a;     v_next[1] = b;     v_next[2] = c;     end
      OP_PX:  begin v_next[0] = one_v; end
      OP_PY:  begin v_next[1] = one_v; end
      OP_PZ:  begin v_next[2] = one_v; end
      OP_SO:  begin v_next[0] = x;     v_next[1] = y;     v_next[2] = z;     end
      OP_S:   begin v_next[0] = x - a; v_next[1] = y - b; v_next[2] = z - c; end
      OP_SX:  begin v_next[0] = x - a; v_next[1] = y;     v_next[2] = z;     end
      OP_SY:  begin v_next[0] = x;     v_next[1] = y - a; v_next[2] = z;     end
      OP_SZ:  begin v_next[0] = x;     v_next[1] = y;     v_next[2] = z - a; end
      OP_CXP: begin v_next[1] = y - a; v_next[2] = z - b; end
      OP_CYP: begin v_next[0] = x - a; v_next[2] = z - b; end
      OP_CZP: begin v_next[0] = x - a; v_next[1] = y - b; end
      OP_CX:  begin v_next[1] = y;     v_next[2] = z;     end
      OP_CY:  begin v_next[0] = x;     v_next[2] = z;     end
      OP_CZ:  begin v_next[0] = x;     v_next[1] = y;     end
      default: deg_next = 1'b1;
    endcase
  end

  logic                     vld1, vld2, vld3, vld4, vld5, vld6;
  logic signed [DIFF_W-1:0] v1 [LANES];
  logic                     deg1, deg2, deg3;
  logic [LANES-1:0]         neg2, neg3;
  logic [DIFF_W-1:0]        mag2 [LANES];
  logic [DIFF_W-1:0]        mag3 [LANES];
  logic [DIFF_W-1:0]        max2;
  logic [LEN_W-1:0]         len3;
  side_t                    side4, side5, side6;
  logic [SQ_W-1:0]          sq5 [LANES];
  logic [SUM_W-1:0]         sum6;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
      vld2 <= 1'b0;
      vld3 <= 1'b0;
      vld4 <= 1'b0;
      vld5 <= 1'b0;
      vld6 <= 1'b0;
    end else if (en) begin
      vld1 <= req.valid;
      vld2 <= vld1;
      vld3 <= vld2;
      vld4 <= vld3;
      vld5 <= vld4;
      vld6 <= vld5;
    end
  end

  // magnitudes and maximum
  logic [DIFF_W-1:0] m_abs [LANES];
  logic [DIFF_W-1:0] m01;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      m_abs[i] = v1[i][DIFF_W-1] ? DIFF_W'(-v1[i]) : DIFF_W'(v1[i]);
    end
    m01 = (m_abs[0] > m_abs[1]) ? m_abs[0] : m_abs[1];
  end

  // normalizing shift
  logic [NORM_W-1:0] mag_sh [LANES];

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      if (len3 > LEN_W'(NORM_W)) begin
        mag_sh[i] = NORM_W'(mag3[i] >> (len3 - LEN_W'(NORM_W)));
      end else begin
        mag_sh[i] = NORM_W'(mag3[i] << (LEN_W'(NORM_W) - len3));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v1   <= v_next;
      deg1 <= deg_next;
      for (int i = 0; i < LANES; i++) begin
        neg2[i] <= v1[i][DIFF_W-1];
        mag2[i] <= m_abs[i];
      end
      max2 <= (m01 > m_abs[2]) ? m01 : m_abs[2];
      deg2 <= deg1;
      len3 <= bit_len(max2);
      mag3 <= mag2;
      neg3 <= neg2;
      deg3 <= deg2 || (max2 == '0);
      side4.neg   <= neg3;
      side4.degen <= deg3;
      for (int i = 0; i < LANES; i++) begin
        side4.mag[i] <= mag_sh[i];
        sq5[i]       <= SQ_W'(side4.mag[i] * side4.mag[i]);
      end
      side5 <= side4;
      sum6  <= SUM_W'(sq5[0]) + SUM_W'(sq5[1]) + SUM_W'(sq5[2]);
      side6 <= side5;
    end
  end

  logic              vld_r;
  logic [ROOT_W-1:0] root_r;
  side_t             side_r;

  qsun_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .vld_in   (vld6),
    .s        (sum6),
    .side_in  (side6),
    .vld_out  (vld_r),
    .root_out (root_r),
    .side_out (side_r)
  );

  // dividends with half-divisor rounding
  logic                          vld7;
  logic [LANES-1:0][DIV_W-1:0]   dvd7;
  logic [ROOT_W-1:0]             root7;
  side_t                         side7;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld7 <= 1'b0;
    end else if (en) begin
      vld7 <= vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < LANES; i++) begin
        dvd7[i] <= {1'b0, side_r.mag[i], 30'd0} + DIV_W'(root_r >> 1);
      end
      root7 <= root_r;
      side7 <= side_r;
    end
  end

  logic                        vld_q;
  logic [LANES-1:0][QUO_W-1:0] quo_q;
  side_t                       side_q;

  qsun_div u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .vld_in   (vld7),
    .dividend (dvd7),
    .divisor  (root7),
    .side_in  (side7),
    .vld_out  (vld_q),
    .quo      (quo_q),
    .side_out (side_q)
  );

  // sign and output register
  logic [OUT_W-1:0] n_out [LANES];

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      if (side_q.degen) begin
        n_out[i] = '0;
      end else if (side_q.neg[i]) begin
        n_out[i] = OUT_W'(-{1'b0, quo_q[i]});
      end else begin
        n_out[i] = OUT_W'({1'b0, quo_q[i]});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_vld <= 1'b0;
    end else if (en) begin
      rsp_vld <= vld_q;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rsp_data.norm_x     <= n_out[0];
      rsp_data.norm_y     <= n_out[1];
      rsp_data.norm_z     <= n_out[2];
      rsp_data.degenerate <= side_q.degen;
    end
  end

endmodule

@@ design/qsun_isqrt.sv @@
// Pipelined integer square root, one result bit per stage.
module qsun_isqrt (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic                           vld_in,
  input  logic [qsun_pkg::SUM_W-1:0]     s,
  input  qsun_pkg::side_t                side_in,
  output logic                           vld_out,
  output logic [qsun_pkg::ROOT_W-1:0]    root_out,
  output qsun_pkg::side_t                side_out
);
  import qsun_pkg::*;

  logic                vld  [0:ROOT_W];
  logic [ROOT_W+1:0]   rem  [0:ROOT_W];
  logic [ROOT_W-1:0]   root [0:ROOT_W];
  logic [SUM_W-1:0]    sb   [0:ROOT_W];
  side_t               side [0:ROOT_W];

  assign vld[0]  = vld_in;
  assign rem[0]  = '0;
  assign root[0] = '0;
  assign sb[0]   = s;
  assign side[0] = side_in;

  for (genvar k = 0; k < ROOT_W; k++) begin : g_step
    logic [ROOT_W+3:0] rem_sh;
    logic [ROOT_W+3:0] trial;
    logic              take;

    assign rem_sh = {rem[k], sb[k][SUM_W-1 -: 2]};
    assign trial  = {2'b00, root[k], 2'b01};
    assign take   = rem_sh >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1]  <= take ? (ROOT_W+2)'(rem_sh - trial) : (ROOT_W+2)'(rem_sh);
        root[k+1] <= {root[k][ROOT_W-2:0], take};
        sb[k+1]   <= {sb[k][SUM_W-3:0], 2'b00};
        side[k+1] <= side[k];
      end
    end
  end

  assign vld_out  = vld[ROOT_W];
  assign root_out = root[ROOT_W];
  assign side_out = side[ROOT_W];

endmodule

@@ design/qsun_div.sv @@
// Pipelined restoring divider, three lanes sharing one divisor, one quotient bit per stage.
module qsun_div (
  input  logic                                            clk,
  input  logic                                            rst,
  input  logic                                            en,
  input  logic                                            vld_in,
  input  logic [qsun_pkg::LANES-1:0][qsun_pkg::DIV_W-1:0] dividend,
  input  logic [qsun_pkg::ROOT_W-1:0]                     divisor,
  input  qsun_pkg::side_t                                 side_in,
  output logic                                            vld_out,
  output logic [qsun_pkg::LANES-1:0][qsun_pkg::QUO_W-1:0] quo,
  output qsun_pkg::side_t                                 side_out
);
  import qsun_pkg::*;

  logic              vld  [0:QUO_W];
  logic [ROOT_W-1:0] dv   [0:QUO_W];
  side_t             side [0:QUO_W];
  logic [LANES-1:0][ROOT_W-1:0] rem [0:QUO_W];
  logic [LANES-1:0][QUO_W-1:0]  lo  [0:QUO_W];

  assign vld[0]  = vld_in;
  assign dv[0]   = divisor;
  assign side[0] = side_in;

  for (genvar l = 0; l < LANES; l++) begin : g_init
    assign rem[0][l] = ROOT_W'(dividend[l][DIV_W-1:QUO_W]);
    assign lo[0][l]  = dividend[l][QUO_W-1:0];
  end

  for (genvar k = 0; k < QUO_W; k++) begin : g_step
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv[k+1]   <= dv[k];
        side[k+1] <= side[k];
      end
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [ROOT_W:0] t;
      logic            take;

      assign t    = {rem[k][l], lo[k][l][QUO_W-1]};
      assign take = t >= {1'b0, dv[k]};

      always_ff @(posedge clk) begin
        if (en) begin
          rem[k+1][l] <= take ? ROOT_W'(t - {1'b0, dv[k]}) : ROOT_W'(t);
          lo[k+1][l]  <= {lo[k][l][QUO_W-2:0], take};
        end
      end
    end
  end

  assign vld_out  = vld[QUO_W];
  assign quo      = lo[QUO_W];
  assign side_out = side[QUO_W];

endmodule

@@ design/qsun_checker.sv @@
// Port-level checks for the unit normal block and their binding.
module qsun_checker (
  input logic                    clk,
  input logic                    rst,
  input logic                    req_ready,
  input logic                    rsp_valid,
  input logic                    rsp_ready,
  input logic signed [31:0]      norm_x,
  input logic signed [31:0]      norm_y,
  input logic signed [31:0]      norm_z,
  input logic                    degenerate
);

  a_zero_on_degen: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && degenerate |-> norm_x == 0 && norm_y == 0 && norm_z == 0)
    else $error("degenerate item with nonzero normal");

  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> norm_x <= 32'sh4000_0000 && norm_x >= -32'sh4000_0000 &&
                  norm_y <= 32'sh4000_0000 && norm_y >= -32'sh4000_0000 &&
                  norm_z <= 32'sh4000_0000 && norm_z >= -32'sh4000_0000)
    else $error("normal component out of range");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |-> !req_ready)
    else $error("input taken while output stalled");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !rsp_valid)
    else $error("output valid right after reset");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(norm_x) && $stable(degenerate))
    else $error("stalled output item changed");

endmodule

bind quadric_surface_unit_normal qsun_checker u_qsun_checker (
  .clk        (clk),
  .rst        (rst),
  .req_ready  (req.ready),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .norm_x     (rsp.data.norm_x),
  .norm_y     (rsp.data.norm_y),
  .norm_z     (rsp.data.norm_z),
  .degenerate (rsp.data.degenerate)
);

@@ bench/tb_qsun_if.sv @@
// Testbench note: channel interfaces come from the design folder; this file holds shared bench types.
`timescale 1ns / 1ps
package tb_qsun_pkg;
  import qsun_pkg::*;

  typedef struct {
    logic signed [OUT_W-1:0] nx;
    logic signed [OUT_W-1:0] ny;
    logic signed [OUT_W-1:0] nz;
    logic                    degen;
  } normal_t;
endpackage

@@ bench/tb.sv @@
// Testbench for the unit normal block: random and directed surface queries checked in order.
`timescale 1ns / 1ps
module tb;
  import qsun_pkg::*;
  import tb_qsun_pkg::*;

  localparam int WATCHDOG = 20000;

  logic clk;
  logic rst;

  qsun_req_if req ();
  qsun_rsp_if rsp ();

  quadric_surface_unit_normal u_top (
    .clk (clk),
    .rst (rst),
    .req (req.sink),
    .rsp (rsp.source)
  );

  req_t    pending_q[$];
  normal_t normal_q[$];
  int      errors;
  int      checked;
  int      degen_seen;
  int      idle_cycles;
  bit      feeding_done;
  bit      drain_wait;
  int      hold_len;
  int      send_gap;
  int      recv_gap;
  int      cycle_cnt;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic logic [63:0] isqrt(input logic [63:0] s);
    logic [63:0] res;
    logic [63:0] bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > s) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (s >= res + bitv) begin
        s   = s - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic normal_t unit_normal(input req_t r);
    normal_t            o;
    logic signed [63:0] a, b, c, x, y, z, one;
    logic signed [63:0] v[3];
    logic [63:0]        mag[3];
    logic [63:0]        m, s, rt, q;
    logic               neg[3];
    logic               ok;
    int                 bl;
    a = r.param_a; b = r.param_b; c = r.param_c;
    x = r.pos_x; y = r.pos_y; z = r.pos_z;
    one = 64'sd1 <<< FRAC_BITS;
    v[0] = 0; v[1] = 0; v[2] = 0;
    ok = 1'b1;
    case (r.operation)
      OP_P: begin v[0] = a; v[1] = b; v[2] = c; end
      OP_PX: v[0] = one;
      OP_PY: v[1] = one;
      OP_PZ: v[2] = one;
      OP_SO: begin v[0] = x; v[1] = y; v[2] = z; end
      OP_S: begin v[0] = x - a; v[1] = y - b; v[2] = z - c; end
      OP_SX: begin v[0] = x - a; v[1] = y; v[2] = z; end
      OP_SY: begin v[0] = x; v[1] = y - a; v[2] = z; end
      OP_SZ: begin v[0] = x; v[1] = y; v[2] = z - a; end
      OP_CXP: begin v[1] = y - a; v[2] = z - b; end
      OP_CYP: begin v[0] = x - a; v[2] = z - b; end
      OP_CZP: begin v[0] = x - a; v[1] = y - b; end
      OP_CX: begin v[1] = y; v[2] = z; end
      OP_CY: begin v[0] = x; v[2] = z; end
      OP_CZ: begin v[0] = x; v[1] = y; end
      default: ok = 1'b0;
    endcase
    m = 0;
    for (int i = 0; i < 3; i++) begin
      neg[i] = v[i][63];
      mag[i] = neg[i] ? -v[i] : v[i];
      if (mag[i] > m) m = mag[i];
    end
    o.nx = 0; o.ny = 0; o.nz = 0; o.degen = 1'b1;
    if (!ok || m == 0) return o;
    bl = 0;
    for (int i = 0; i < 64; i++) if (m[i]) bl = i + 1;
    s = 0;
    for (int i = 0; i < 3; i++) begin
      if (bl > 31) mag[i] = mag[i] >> (bl - 31);
      else mag[i] = mag[i] << (31 - bl);
      s = s + mag[i] * mag[i];
    end
    rt = isqrt(s);
    for (int i = 0; i < 3; i++) begin
      q = ((mag[i] << 30) + (rt >> 1)) / rt;
      if (neg[i]) q = -q;
      if (i == 0) o.nx = q[31:0];
      else if (i == 1) o.ny = q[31:0];
      else o.nz = q[31:0];
    end
    o.degen = 1'b0;
    return o;
  endfunction

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0;
      3: return $urandom_range(0, 7) - 3;
      4: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  function automatic req_t random_query();
    req_t r;
    r.operation = 4'($urandom_range(0, 15));
    r.param_a = pick_coord();
    r.param_b = pick_coord();
    r.param_c = pick_coord();
    r.pos_x = pick_coord();
    r.pos_y = pick_coord();
    r.pos_z = pick_coord();
    if ($urandom_range(0, 7) == 0) begin
      r.pos_x = r.param_a;
      r.pos_y = r.param_b;
      r.pos_z = r.param_c;
    end
    return r;
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s at result %0d: got %h want %h", what, checked, got, want);
    errors++;
  endtask

  function automatic int pick_gap();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 1) == 0) return 0;
    return $urandom_range(1, 3);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
      req.data  <= '0;
      send_gap  <= 0;
    end else if (!req.valid || req.ready) begin
      if (send_gap > 0 || drain_wait || pending_q.size() == 0) begin
        req.valid <= 1'b0;
        if (send_gap > 0) send_gap <= send_gap - 1;
      end else begin
        req.valid <= 1'b1;
        req.data  <= pending_q.pop_front();
        send_gap  <= (cycle_cnt / 1024) % 4 == 3 ? 0 : pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && req.valid && req.ready) normal_q.push_back(unit_normal(req.data));
  end

  always @(posedge clk) begin
    normal_t e;
    if (rst) begin
      rsp.ready <= 1'b0;
      recv_gap  <= 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (normal_q.size() == 0) begin
          $display("unexpected result %0d", checked);
          errors++;
        end else begin
          e = normal_q.pop_front();
          if (rsp.data.norm_x !== e.nx) report("norm_x", rsp.data.norm_x, e.nx);
          if (rsp.data.norm_y !== e.ny) report("norm_y", rsp.data.norm_y, e.ny);
          if (rsp.data.norm_z !== e.nz) report("norm_z", rsp.data.norm_z, e.nz);
          if (rsp.data.degenerate !== e.degen)
            report("degenerate", rsp.data.degenerate, e.degen);
          if (e.degen) degen_seen++;
        end
        checked++;
      end
      if (hold_len > 0) begin
        rsp.ready <= 1'b0;
        hold_len  <= hold_len - 1;
      end else if (recv_gap > 0) begin
        rsp.ready <= 1'b0;
        recv_gap  <= recv_gap - 1;
      end else begin
        rsp.ready <= 1'b1;
        recv_gap  <= (cycle_cnt / 1024) % 4 == 3 ? 0 : pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
        $display("watchdog expired with %0d results outstanding", normal_q.size());
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    req_t r;
    logic [31:0] edges[4];
    edges = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff};
    rst = 1'b1;
    hold_len = 0;
    drain_wait = 1'b0;
    errors = 0;
    checked = 0;
    degen_seen = 0;
    idle_cycles = 0;
    cycle_cnt = 0;
    req.valid = 1'b0;
    req.data = '0;
    rsp.ready = 1'b0;
    for (int k = 0; k < 16; k++) begin
      r = '0;
      r.operation = 4'(k);
      r.param_a = edges[k % 4];
      r.param_b = edges[(k + 1) % 4];
      r.param_c = edges[(k + 2) % 4];
      r.pos_x = edges[(k + 1) % 4];
      r.pos_y = edges[(k + 3) % 4];
      r.pos_z = edges[k % 4];
      pending_q.push_back(r);
    end
    r = '0;
    r.operation = OP_SO;
    pending_q.push_back(r);
    r.operation = OP_P;
    pending_q.push_back(r);
    r.operation = OP_S;
    r.param_a = 32'h1234_5678; r.pos_x = 32'h1234_5678;
    pending_q.push_back(r);
    r.operation = OP_SO;
    r.pos_x = 32'h0; r.pos_y = 32'h7fff_ffff; r.pos_z = 32'h0;
    pending_q.push_back(r);
    r.operation = OP_CX;
    r.pos_y = 32'h0001_0000; r.pos_z = 32'hffff_0000;
    pending_q.push_back(r);
    r.operation = OP_S;
    r.param_a = 32'h7fff_ffff; r.pos_x = 32'h8000_0000;
    r.param_b = 32'h8000_0000; r.pos_y = 32'h7fff_ffff;
    r.param_c = 32'h0; r.pos_z = 32'h1;
    pending_q.push_back(r);
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    for (int n = 0; n < 800; n++) pending_q.push_back(random_query());
    wait (pending_q.size() == 0);
    hold_len <= 300;
    for (int n = 0; n < 200; n++) pending_q.push_back(random_query());
    wait (pending_q.size() == 0);
    drain_wait <= 1'b1;
    wait (normal_q.size() == 0);
    @(posedge clk);
    drain_wait <= 1'b0;
    for (int n = 0; n < 630; n++) pending_q.push_back(random_query());
    wait (pending_q.size() == 0 && !req.valid);
    wait (normal_q.size() == 0);
    repeat (100) @(posedge clk);
    $display("covered %0d queries over all surface kinds, %0d degenerate", checked, degen_seen);
    $display("including edge coordinates, a long output stall and a full drain pause");
    if (errors == 0 && normal_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
